@@ rtl/krt_pkg.sv @@
// Shared constants and types for the keyed record table.
`default_nettype none

package krt_pkg;

    localparam int DEPTH_DEF    = 32;
    localparam int RESULT_LIMIT = 32;
    localparam int KEY_W        = 16;
    localparam int VAL_W        = 16;
    localparam int OP_W         = 3;
    localparam int ST_W         = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_UPDATE = 3'd1,
        OP_DELETE = 3'd2,
        OP_LIST   = 3'd3,
        OP_SEARCH = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

endpackage

`default_nettype wire

@@ rtl/keyed_record_table.sv @@
// Keyed record table: packed, insertion-ordered key/value store in one RAM.
`default_nettype none

// Records live packed in insertion order in a single synchronous RAM of
// DEPTH words (key in the upper half, value in the lower), read one entry
// per cycle through a registered read port. A command is taken when start
// is high and busy is low. Add, and any other command that finds the table
// empty, gives its single beat and leaves busy low. Update, delete and
// search scan from slot 0 one entry a cycle: a match gives its result beat,
// and a scan that reaches the last record unmatched reports ST_NOT_FOUND.
// Delete then moves each later record down one slot, one RAM write per
// cycle, so busy stays high until the last record has moved. List streams
// one record per cycle, at most 32 records, with o_last on the final beat.
// Every result beat is on the o_ ports for exactly one cycle, marked by
// o_strobe; the receiver cannot stall it. Op codes 5 to 7 are dropped with
// no result. The RAM is not cleared at reset; the fill count, state and
// result strobe are.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [OP_W-1:0]  i_op,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0] i_value,
    output logic                  o_strobe,
    output logic [ST_W-1:0]       o_status,
    output logic [KEY_W-1:0]      o_found_key,
    output logic [VAL_W-1:0]      o_found_value,
    output logic                  o_last
);

    localparam int IW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int REC_W    = KEY_W + VAL_W;
    localparam int LIST_MAX = (DEPTH < RESULT_LIMIT) ? DEPTH : RESULT_LIMIT;
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW-1:0] LIST_CNT  = CW'(LIST_MAX);
    localparam logic [CW-1:0] LIST_LAST = CW'(LIST_MAX - 1);
    localparam logic [CW-1:0] ONE       = CW'(1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_LIST  = 4'b1000
    } t_state;

    // record RAM
    logic [REC_W-1:0] r_mem [DEPTH];
    logic [REC_W-1:0] r_rd_data;

    // control
    t_state            r_state,  n_state;
    logic [CW-1:0]     r_fill,   n_fill;
    logic [CW-1:0]     r_idx,    n_idx;      // next slot to read
    logic [CW-1:0]     r_rd_idx, n_rd_idx;   // slot held in r_rd_data
    logic [OP_W-1:0]   r_op,     n_op;
    logic [KEY_W-1:0]  r_key,    n_key;
    logic [VAL_W-1:0]  r_val,    n_val;

    // result beat
    logic              r_strobe, n_strobe;
    logic [ST_W-1:0]   r_status, n_status;
    logic [KEY_W-1:0]  r_okey,   n_okey;
    logic [VAL_W-1:0]  r_oval,   n_oval;
    logic              r_last,   n_last;

    // RAM port controls
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [REC_W-1:0]  wr_data;
    logic [IW-1:0]     rd_addr;

    logic [KEY_W-1:0]  rd_key;
    logic [VAL_W-1:0]  rd_val;
    logic [CW-1:0]     fill_m1;
    logic [CW-1:0]     shift_dst;
    logic [CW-1:0]     list_last;

    assign rd_key    = r_rd_data[REC_W-1:VAL_W];
    assign rd_val    = r_rd_data[VAL_W-1:0];
    assign fill_m1   = r_fill - ONE;
    assign shift_dst = r_rd_idx - ONE;
    assign list_last = (r_fill > LIST_CNT) ? LIST_LAST : fill_m1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_rd_idx = r_rd_idx;
        n_op     = r_op;
        n_key    = r_key;
        n_val    = r_val;
        n_strobe = 1'b0;
        n_status = ST_OK;
        n_okey   = '0;
        n_oval   = '0;
        n_last   = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        rd_addr  = '0;

        // Reads run one slot ahead; while idle slot 0 is always fetched so
        // a scan or list starts with data already in hand.
        if (r_state != S_IDLE) begin
            rd_addr = (r_idx < FULL_CNT) ? r_idx[IW-1:0] : '0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_op;
                    n_key    = i_key;
                    n_val    = i_value;
                    n_rd_idx = '0;
                    n_idx    = ONE;
                    unique case (i_op)
                        OP_ADD: begin
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                            if (r_fill == FULL_CNT) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_fill[IW-1:0];
                                wr_data = {i_key, i_value};
                                n_fill  = r_fill + ONE;
                                n_okey  = i_key;
                                n_oval  = i_value;
                            end
                        end
                        OP_UPDATE, OP_DELETE, OP_SEARCH: begin
                            if (r_fill == '0) begin
                                n_strobe = 1'b1;
                                n_last   = 1'b1;
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_LIST: begin
                            if (r_fill == '0) begin
                                n_strobe = 1'b1;
                                n_last   = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                n_idx    = r_idx + ONE;
                n_rd_idx = r_idx;
                if (rd_key == r_key) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_okey   = rd_key;
                    n_oval   = rd_val;
                    priority if (r_op == OP_UPDATE) begin
                        wr_en   = 1'b1;
                        wr_addr = r_rd_idx[IW-1:0];
                        wr_data = {rd_key, r_val};
                        n_oval  = r_val;
                        n_state = S_IDLE;
                    end else if (r_op == OP_DELETE) begin
                        // removing the tail record needs no move
                        if (r_rd_idx == fill_m1) begin
                            n_fill  = fill_m1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_SHIFT;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (r_rd_idx == fill_m1) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_IDLE;
                end
            end

            S_SHIFT: begin
                // r_rd_data holds slot j+1; write it to slot j
                n_idx    = r_idx + ONE;
                n_rd_idx = r_idx;
                wr_en    = 1'b1;
                wr_addr  = shift_dst[IW-1:0];
                wr_data  = r_rd_data;
                if (r_rd_idx == fill_m1) begin
                    n_fill  = fill_m1;
                    n_state = S_IDLE;
                end
            end

            S_LIST: begin
                n_idx    = r_idx + ONE;
                n_rd_idx = r_idx;
                n_strobe = 1'b1;
                n_okey   = rd_key;
                n_oval   = rd_val;
                if (r_rd_idx == list_last) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_status <= n_status;
        r_okey   <= n_okey;
        r_oval   <= n_oval;
        r_last   <= n_last;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_found_key   = r_okey;
    assign o_found_value = r_oval;
    assign o_last        = r_last;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count beyond table depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_found_key == '0 && o_found_value == '0
            && o_last))
        else $error("error beat carries a record or is not last");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_ADD && r_fill != FULL_CNT)
            |=> (r_fill == $past(r_fill) + ONE))
        else $error("add did not grow the table");

    // the delete beat goes out during the first move cycle
    a_shift_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> wr_en)
        else $error("shift cycle without a RAM write");

    // only a delete still moving records stays busy past its beat
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_strobe && n_last) |=> (!busy || r_state == S_SHIFT))
        else $error("final beat while still busy");
`endif

endmodule

`default_nettype wire
